// ===== src/fen_pkg.sv =====
`timescale 1ns / 1ps
package fen_pkg;

  typedef enum logic [3:0] {
    PH_PLACE      = 4'd0,
    PH_SIDE       = 4'd1,
    PH_CASTLE_PRE = 4'd2,
    PH_CASTLE     = 4'd3,
    PH_EP_PRE     = 4'd4,
    PH_EP_RANK    = 4'd5,
    PH_HALF_PRE   = 4'd6,
    PH_HALF       = 4'd7,
    PH_MOVE_PRE   = 4'd8,
    PH_MOVE       = 4'd9,
    PH_MOVE_TAIL  = 4'd10
  } phase_e;

  typedef enum logic [2:0] {
    CK_OTHER = 3'd0,
    CK_SPACE = 3'd1,
    CK_SLASH = 3'd2,
    CK_DIGIT = 3'd3,
    CK_PIECE = 3'd4,
    CK_DASH  = 3'd5,
    CK_FILE  = 3'd6
  } char_kind_e;

  // classified character handed from front to back
  typedef struct packed {
    logic [7:0] ch;
    char_kind_e kind;
    logic [3:0] val;    // digit value or piece code
    logic       last;
  } cls_item_t;

  localparam int unsigned QueueDepth = 2;
  localparam logic [15:0] CountMax = 16'hFFFF;

  function automatic logic [3:0] piece_code(input logic [7:0] c, output logic ok);
    ok = 1'b1;
    unique case (c)
      "K": piece_code = 4'd0;
      "Q": piece_code = 4'd1;
      "R": piece_code = 4'd2;
      "B": piece_code = 4'd3;
      "N": piece_code = 4'd4;
      "P": piece_code = 4'd5;
      "k": piece_code = 4'd6;
      "q": piece_code = 4'd7;
      "r": piece_code = 4'd8;
      "b": piece_code = 4'd9;
      "n": piece_code = 4'd10;
      "p": piece_code = 4'd11;
      default: begin
        piece_code = 4'd0;
        ok = 1'b0;
      end
    endcase
  endfunction

endpackage

// ===== src/fen_front.sv =====
`timescale 1ns / 1ps
module fen_front
  import fen_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic      in_last_i,
  output logic      q_valid_o,
  input  logic      q_ready_i,
  output cls_item_t q_item_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  cls_item_t mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0] cnt_q, cnt_d;
  cls_item_t cls;
  logic pok;
  logic [3:0] pcode;

  always_comb begin
    cls = '0;
    cls.ch = in_char_i;
    cls.last = in_last_i;
    pcode = piece_code(in_char_i, pok);
    if (in_char_i == " ") begin
      cls.kind = CK_SPACE;
    end else if (in_char_i == "/") begin
      cls.kind = CK_SLASH;
    end else if (in_char_i == "-") begin
      cls.kind = CK_DASH;
    end else if (in_char_i >= "0" && in_char_i <= "9") begin
      cls.kind = CK_DIGIT;
      cls.val = 4'(in_char_i - 8'd48);
    end else if (pok) begin
      cls.kind = CK_PIECE;
      cls.val = pcode;
    end else begin
      cls.kind = CK_OTHER;
    end
    // file letters overlap piece letters; back end checks raw char
    if (in_char_i >= "a" && in_char_i <= "h" && !pok) begin
      cls.kind = CK_FILE;
    end
  end

  logic push, pop;
  assign in_ready_o = (cnt_q != (PtrW+1)'(QueueDepth));
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != '0);
  assign pop = q_valid_o && q_ready_i;
  assign q_item_o = mem_q[rd_q];

  always_comb begin
    wr_d = push ? ((wr_q == PtrW'(QueueDepth-1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d = pop ? ((rd_q == PtrW'(QueueDepth-1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cls;
  end

endmodule

// ===== src/fen_back.sv =====
`timescale 1ns / 1ps
module fen_back
  import fen_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  output logic       q_ready_o,
  input  cls_item_t  q_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [63:0] out_data_o,
  output logic       out_last_o
);

  phase_e phase_q, phase_d;
  logic [2:0] rank_q, rank_d;
  logic [3:0] file_q, file_d;
  logic first_q, first_d, err_q, err_d, side_q, side_d, epf_q, epf_d;
  logic [3:0] cas_q, cas_d;
  logic [5:0] ep_q, ep_d;
  logic [15:0] half_q, half_d, move_q, move_d;
  logic ov_q, ov_d;
  logic [63:0] od_q, od_d;
  logic lst_q, lst_d;

  logic take;
  assign q_ready_o = !ov_q || out_ready_i;
  assign take = q_valid_i && q_ready_o;
  assign out_valid_o = ov_q;
  assign out_data_o = od_q;
  assign out_last_o = lst_q;

  function automatic logic [15:0] add_dig(input logic [15:0] acc, input logic [3:0] d);
    logic [20:0] v;
    v = {acc, 3'b000} + {4'b0, acc, 1'b0} + 21'(d);
    add_dig = (v > 21'(CountMax)) ? CountMax : v[15:0];
  endfunction

  logic cl_ok;
  logic [3:0] cl_bits;
  logic [4:0] fsum;
  logic wv, done, erro;
  logic [5:0] sq;
  logic [3:0] pc;
  logic [7:0] c;

  always_comb begin
    phase_d = phase_q; rank_d = rank_q; file_d = file_q; first_d = first_q;
    err_d = err_q; side_d = side_q; epf_d = epf_q; cas_d = cas_q; ep_d = ep_q;
    half_d = half_q; move_d = move_q; ov_d = ov_q; od_d = od_q; lst_d = lst_q;
    wv = 1'b0; sq = '0; pc = '0; done = 1'b0; erro = 1'b0;
    c = q_item_i.ch;
    fsum = {1'b0, file_q} + {1'b0, q_item_i.val};
    cl_ok = 1'b1;
    cl_bits = cas_q;
    unique case (c)
      "K": cl_bits = cas_q | 4'b0001;
      "Q": cl_bits = cas_q | 4'b0010;
      "k": cl_bits = cas_q | 4'b0100;
      "q": cl_bits = cas_q | 4'b1000;
      "-": cl_bits = 4'b0000;
      default: cl_ok = 1'b0;
    endcase
    if (out_ready_i) ov_d = 1'b0;
    if (take) begin
      first_d = 1'b1;
      if (!err_q) begin
        unique case (phase_q)
          PH_PLACE: begin
            if (q_item_i.kind == CK_SPACE) begin
              if (rank_q != 3'd0) err_d = 1'b1;
              else phase_d = PH_SIDE;
            end else if (q_item_i.kind == CK_SLASH) begin
              if (rank_q == 3'd0) err_d = 1'b1;
              else begin rank_d = rank_q - 3'd1; file_d = '0; end
            end else if (q_item_i.kind == CK_DIGIT && c >= "1" && c <= "8") begin
              file_d = fsum[3:0];
              if (fsum > 5'd8) err_d = 1'b1;
            end else if (q_item_i.kind == CK_PIECE && file_q < 4'd8) begin
              wv = 1'b1;
              sq = {rank_q, file_q[2:0]};
              pc = q_item_i.val;
              file_d = file_q + 4'd1;
            end else begin
              err_d = 1'b1;
            end
          end
          PH_SIDE: begin
            if (c == "w") begin side_d = 1'b1; phase_d = PH_CASTLE_PRE; end
            else if (c == "b") begin side_d = 1'b0; phase_d = PH_CASTLE_PRE; end
            else if (c != " ") err_d = 1'b1;
          end
          PH_CASTLE_PRE: begin
            if (c != " ") begin
              if (cl_ok) begin
                cas_d = (c == "-") ? 4'b0000 : (cl_bits & ~cas_q);
                phase_d = PH_CASTLE;
              end else begin
                cas_d = '0;
                err_d = 1'b1;
              end
            end
          end
          PH_CASTLE: begin
            if (c == " ") phase_d = PH_EP_PRE;
            else if (cl_ok) cas_d = cl_bits;
            else err_d = 1'b1;
          end
          PH_EP_PRE: begin
            if (c == "-") begin epf_d = 1'b0; phase_d = PH_HALF_PRE; end
            else if (c >= "a" && c <= "h") begin
              ep_d = {3'b000, c[2:0] - 3'd1};
              phase_d = PH_EP_RANK;
            end else if (c != " ") err_d = 1'b1;
          end
          PH_EP_RANK: begin
            if (c == "3") begin
              ep_d = {3'd2, ep_q[2:0]}; epf_d = 1'b1; phase_d = PH_HALF_PRE;
            end else if (c == "6") begin
              ep_d = {3'd5, ep_q[2:0]}; epf_d = 1'b1; phase_d = PH_HALF_PRE;
            end else err_d = 1'b1;
          end
          PH_HALF_PRE: begin
            if (q_item_i.kind == CK_DIGIT) begin
              half_d = add_dig('0, q_item_i.val); phase_d = PH_HALF;
            end else if (c != " ") err_d = 1'b1;
          end
          PH_HALF: begin
            if (q_item_i.kind == CK_DIGIT) half_d = add_dig(half_q, q_item_i.val);
            else if (c == " ") phase_d = PH_MOVE_PRE;
            else err_d = 1'b1;
          end
          PH_MOVE_PRE: begin
            if (q_item_i.kind == CK_DIGIT) begin
              move_d = add_dig('0, q_item_i.val); phase_d = PH_MOVE;
            end else if (c != " ") phase_d = PH_MOVE_TAIL;
          end
          PH_MOVE: begin
            if (q_item_i.kind == CK_DIGIT) move_d = add_dig(move_q, q_item_i.val);
            else phase_d = PH_MOVE_TAIL;
          end
          default: ;
        endcase
      end
      od_d = '0;
      od_d[0] = !first_q;
      od_d[1] = wv;
      od_d[7:2] = sq;
      od_d[11:8] = pc;
      if (q_item_i.last) begin
        done = 1'b1;
        erro = err_d || !(phase_d == PH_MOVE_PRE || phase_d == PH_MOVE ||
                          phase_d == PH_MOVE_TAIL);
        od_d[12] = erro;
        od_d[13] = side_d;
        od_d[17:14] = cas_d;
        od_d[18] = epf_d;
        od_d[24:19] = epf_d ? ep_d : 6'd0;
        od_d[40:25] = half_d;
        od_d[56:41] = move_d;
        phase_d = PH_PLACE; rank_d = 3'd7; file_d = '0; first_d = 1'b0;
        err_d = 1'b0; side_d = 1'b0; cas_d = '0; epf_d = 1'b0; ep_d = '0;
        half_d = '0; move_d = '0;
      end
      lst_d = done;
      ov_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PLACE; rank_q <= 3'd7; file_q <= '0; first_q <= 1'b0;
      err_q <= 1'b0; side_q <= 1'b0; cas_q <= '0; epf_q <= 1'b0; ep_q <= '0;
      half_q <= '0; move_q <= '0; ov_q <= 1'b0;
    end else begin
      phase_q <= phase_d; rank_q <= rank_d; file_q <= file_d; first_q <= first_d;
      err_q <= err_d; side_q <= side_d; cas_q <= cas_d; epf_q <= epf_d; ep_q <= ep_d;
      half_q <= half_d; move_q <= move_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
    lst_q <= lst_d;
  end

endmodule

// ===== src/fen_position_parser.sv =====
`timescale 1ns / 1ps
// Channel | Dir | tdata                         | tlast
// s_axis  | in  | [7:0] char_in                 | last_char
// m_axis  | out | fields listed at m_axis_tdata | done_res
// One item per cycle sustained while the output is not held; each character is
// classified in the front, queued (two entries), then applied to the parse state
// by the back end and registered onto the output.
// Reset clears parse state and queue; a held output backs up the queue, and
// s_axis_tready drops once both queue entries are taken.
module fen_position_parser
  import fen_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // char_in
  input  logic        s_axis_tlast_i,   // last_char
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // board_clear, write_valid, square[6], piece[4], parse_error,
  // white_to_move, castle_rights[4], ep_valid, ep_square[6],
  // halfmove_count[16], move_count[16], zero pad
  output logic [63:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o    // done_res
);

  logic q_valid, q_ready;
  cls_item_t q_item;

  fen_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .in_char_i(s_axis_tdata_i), .in_last_i(s_axis_tlast_i),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  fen_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .out_data_o(m_axis_tdata_o), .out_last_o(m_axis_tlast_o)
  );

endmodule
